// ===== rtl/gaussian_particle_repulsion_defines.svh =====
// Assertion macros for the Gaussian repulsion block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GAUSSIAN_PARTICLE_REPULSION_DEFINES_SVH
`define GAUSSIAN_PARTICLE_REPULSION_DEFINES_SVH

// same-cycle implication
`define GPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gpr_pkg.sv =====
// Shared types, constants and helpers for the Gaussian repulsion block.
// No dependencies.
package gpr_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int EXP_DEPTH_DEF     = 256;

  localparam int POS_W   = 16;
  localparam int FORCE_W = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 2;
  localparam int D2_W    = 35;
  localparam int ROOT_W  = 18;
  localparam int DIV_NW  = 64;
  localparam int DIV_DW  = 32;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  localparam logic [CFG_IW-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CUTOFF = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      last_force;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_ACCCLR, OP_ROWEND, OP_READ, OP_SQ,
    OP_DIVK, OP_SQRT, OP_DIVW, OP_ACC, OP_MULG, OP_MULD, OP_DIVI,
    OP_LATI, OP_DIVJ, OP_LATJ, OP_WRI, OP_WRJ, OP_OUTRD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis;   // 0: x, 1: y
  } dp_cmd_t;

  typedef struct packed {
    logic early_zero;
    logic ws_zero;
    logic k_big;
    logic w_zero;
    logic div_done;
    logic sqrt_done;
  } dp_stat_t;

  // one step of the exp(-k/16) recurrence, Q0.32 with round to nearest
  function automatic logic [63:0] exp_next(input logic [63:0] e);
    logic [127:0] p;
    p = 128'(e) * 128'(EXP_STEP_Q32) + 128'h8000_0000;
    return p[95:32];
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat32(input logic signed [60:0] v);
    if (v > 61'sd2147483647)
      return 32'sh7FFF_FFFF;
    else if (v < -61'sd2147483648)
      return 32'sh8000_0000;
    else
      return v[31:0];
  endfunction

endpackage

// ===== rtl/gpr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gpr_pkg.
module gpr_div
  import gpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r, done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem_r, num_r[DIV_NW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[DIV_NW-2:0], qbit};
      rem_r <= qbit ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

// ===== rtl/gpr_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on gpr_pkg.
module gpr_sqrt
  import gpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] rad,
  output logic [ROOT_W-1:0]   root,
  output logic                done
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W+2:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                run_r, done_r;
  logic [ROOT_W+2:0]   rem_sh, trial;
  logic                hit;

  assign rem_sh = {rem_r[ROOT_W:0], rad_r[2*ROOT_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign hit    = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= hit ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], hit};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== rtl/gpr_datapath.sv =====
// Datapath: config registers, particle/sum/force stores, pair arithmetic.
// Depends on gpr_pkg, gpr_div, gpr_sqrt.
module gpr_datapath
  import gpr_pkg::*;
#(
  parameter int MAX_P     = MAX_PARTICLES_DEF,
  parameter int EXP_DEPTH = EXP_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  in_item_t                   in_data,
  input  dp_cmd_t                    cmd,
  input  logic [$clog2(MAX_P)-1:0]   idx_i,
  input  logic [$clog2(MAX_P)-1:0]   idx_j,
  output dp_stat_t                   stat,
  output logic signed [FORCE_W-1:0]  force_x,
  output logic signed [FORCE_W-1:0]  force_y
);

  localparam int AW = $clog2(MAX_P);
  localparam int KW = $clog2(EXP_DEPTH);

  typedef logic [16:0] exp_tab_t [EXP_DEPTH];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] e;
    e = 64'h1_0000_0000;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      t[k] = 17'((e + 64'h8000) >> 16);
      e    = exp_next(e);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // config
  logic [CFG_W-1:0] gain_r, kw_r, cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd256;
      kw_r   <= 16'd77;
      cut_r  <= 16'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:   gain_r <= cfg_data;
        REG_WIDTH:  kw_r   <= cfg_data;
        REG_CUTOFF: cut_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  logic signed [POS_W-1:0]   x_mem  [MAX_P];
  logic signed [POS_W-1:0]   y_mem  [MAX_P];
  logic [31:0]               ws_mem [MAX_P];
  logic signed [FORCE_W-1:0] fx_mem [MAX_P];
  logic signed [FORCE_W-1:0] fy_mem [MAX_P];

  logic signed [POS_W-1:0]   xi_r, yi_r, xj_r, yj_r;
  logic [31:0]               wsi_r, wsj_r;
  logic signed [FORCE_W-1:0] fxi_r, fyi_r, fxj_r, fyj_r;

  // arithmetic registers
  logic [31:0]        c2_r, s2_r;
  logic signed [16:0] dx_r, dy_r;
  logic [D2_W-1:0]    d2_r;
  logic [16:0]        entry_r;
  logic [47:0]        acc_r;
  logic [40:0]        gw_r;
  logic [57:0]        mag_r, ti_r, tj_r;

  // divider / sqrt
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;
  logic [ROOT_W-1:0] root;
  logic              sqrt_done;

  gpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  gpr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_SQRT),
    .rad   ({1'b0, d2_r}),
    .root  (root),
    .done  (sqrt_done)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DIVK: begin
        div_start = 1'b1;
        div_num   = 64'({d2_r, 4'b0000}) + 64'(s2_r >> 1);
        div_den   = s2_r;
      end
      OP_DIVW: begin
        div_start = 1'b1;
        div_num   = 64'({entry_r, 8'h00});
        div_den   = 32'(root);
      end
      OP_DIVI: begin
        div_start = 1'b1;
        div_num   = 64'(mag_r);
        div_den   = wsi_r;
      end
      OP_DIVJ: begin
        div_start = 1'b1;
        div_num   = 64'(mag_r);
        div_den   = wsj_r;
      end
      default: ;
    endcase
  end

  // pair differences and squared distance
  logic signed [16:0] dx, dy, dsel;
  logic [16:0]        ux, uy, ud;

  assign dx   = {xi_r[POS_W-1], xi_r} - {xj_r[POS_W-1], xj_r};
  assign dy   = {yi_r[POS_W-1], yi_r} - {yj_r[POS_W-1], yj_r};
  assign ux   = dx[16] ? 17'(-dx) : 17'(dx);
  assign uy   = dy[16] ? 17'(-dy) : 17'(dy);
  assign dsel = cmd.axis ? dy_r : dx_r;
  assign ud   = dsel[16] ? 17'(-dsel) : 17'(dsel);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PREP: begin
        c2_r <= 32'(cut_r) * 32'(cut_r);
        s2_r <= 32'(kw_r) * 32'(kw_r);
      end
      OP_SQ: begin
        dx_r <= dx;
        dy_r <= dy;
        d2_r <= D2_W'(ux) * D2_W'(ux) + D2_W'(uy) * D2_W'(uy);
      end
      OP_SQRT:   entry_r <= EXP_TAB[div_q[KW-1:0]];
      OP_ACCCLR: acc_r   <= '0;
      OP_ACC:    acc_r   <= acc_r + 48'(div_q[24:0]);
      OP_MULG:   gw_r    <= 41'(gain_r) * 41'(div_q[24:0]);
      OP_MULD:   mag_r   <= 58'(gw_r) * 58'(ud);
      OP_LATI:   ti_r    <= div_q[57:0];
      OP_LATJ:   tj_r    <= div_q[57:0];
      default: ;
    endcase
  end

  // force update with saturation
  logic signed [59:0]        tis, tjs;
  logic signed [FORCE_W-1:0] fi, fj, f_wdata;
  logic [AW-1:0]             f_addr;
  logic                      fx_we, fy_we, upd;
  logic [31:0]               ws_sat;

  assign tis    = dsel[16] ? -$signed({2'b00, ti_r}) : $signed({2'b00, ti_r});
  assign tjs    = dsel[16] ? -$signed({2'b00, tj_r}) : $signed({2'b00, tj_r});
  assign fi     = cmd.axis ? fyi_r : fxi_r;
  assign fj     = cmd.axis ? fyj_r : fxj_r;
  assign upd    = (cmd.op == OP_WRI) || (cmd.op == OP_WRJ);
  assign fx_we  = (cmd.op == OP_ROWEND) || (upd && !cmd.axis);
  assign fy_we  = (cmd.op == OP_ROWEND) || (upd && cmd.axis);
  assign f_addr = (cmd.op == OP_WRJ) ? idx_j : idx_i;
  assign ws_sat = (acc_r > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_r[31:0];

  always_comb begin
    case (cmd.op)
      OP_WRI:  f_wdata = sat32(61'(fi) + 61'(tis));
      OP_WRJ:  f_wdata = sat32(61'(fj) - 61'(tjs));
      default: f_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      x_mem[idx_i] <= in_data.pos_x;
      y_mem[idx_i] <= in_data.pos_y;
    end
    if (cmd.op == OP_ROWEND) ws_mem[idx_i] <= ws_sat;
    if (fx_we) fx_mem[f_addr] <= f_wdata;
    if (fy_we) fy_mem[f_addr] <= f_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      xi_r  <= x_mem[idx_i];
      yi_r  <= y_mem[idx_i];
      xj_r  <= x_mem[idx_j];
      yj_r  <= y_mem[idx_j];
      wsi_r <= ws_mem[idx_i];
      wsj_r <= ws_mem[idx_j];
      fxi_r <= fx_mem[idx_i];
      fyi_r <= fy_mem[idx_i];
      fxj_r <= fx_mem[idx_j];
      fyj_r <= fy_mem[idx_j];
    end else if (cmd.op == OP_OUTRD) begin
      fxi_r <= fx_mem[idx_i];
      fyi_r <= fy_mem[idx_i];
    end
  end

  assign stat.early_zero = (d2_r == '0) || (d2_r >= D2_W'(c2_r)) || (kw_r == '0);
  assign stat.ws_zero    = (wsi_r == '0) || (wsj_r == '0);
  assign stat.k_big      = (div_q >= DIV_NW'(EXP_DEPTH));
  assign stat.w_zero     = (div_q == '0);
  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;

  assign force_x = fxi_r;
  assign force_y = fyi_r;

endmodule

// ===== rtl/gpr_ctrl.sv =====
// Controller: load counting, pair loops, per-pair step sequencing and force output.
// Depends on gpr_pkg.
module gpr_ctrl
  import gpr_pkg::*;
#(
  parameter int MAX_P = MAX_PARTICLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     last_particle,
  output logic                     busy,
  output dp_cmd_t                  cmd,
  output logic [$clog2(MAX_P)-1:0] idx_i,
  output logic [$clog2(MAX_P)-1:0] idx_j,
  input  dp_stat_t                 stat,
  output logic                     out_valid,
  output logic                     out_last
);

  localparam int AW = $clog2(MAX_P);
  localparam int IW = $clog2(MAX_P + 1) + 1;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_PREP   = 20'h00002,
    ST_ROW    = 20'h00004,
    ST_SEL    = 20'h00008,
    ST_ROWEND = 20'h00010,
    ST_RD     = 20'h00020,
    ST_SQ     = 20'h00040,
    ST_CHK    = 20'h00080,
    ST_KW     = 20'h00100,
    ST_SW     = 20'h00200,
    ST_WW     = 20'h00400,
    ST_MD     = 20'h00800,
    ST_DI     = 20'h01000,
    ST_DIW    = 20'h02000,
    ST_DJ     = 20'h04000,
    ST_DJW    = 20'h08000,
    ST_WI     = 20'h10000,
    ST_WJ     = 20'h20000,
    ST_OUT    = 20'h40000,
    ST_OEMIT  = 20'h80000
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic          phase_r, phase_nxt, axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    idx_i     = i_r[AW-1:0];
    idx_j     = j_r[AW-1:0];
    out_valid = 1'b0;
    out_last  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        idx_i = cnt_r[AW-1:0];
        if (start) begin
          if (cnt_r < IW'(MAX_P)) begin
            cmd.op  = OP_LOAD;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (last_particle) state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op    = OP_PREP;
        phase_nxt = 1'b0;
        i_nxt     = '0;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        cmd.op    = OP_ACCCLR;
        j_nxt     = '0;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (!phase_r) begin
          if (j_r == cnt_r)    state_nxt = ST_ROWEND;
          else if (j_r == i_r) j_nxt = j_r + 1'b1;
          else                 state_nxt = ST_RD;
        end else begin
          if (i_r + 1'b1 >= cnt_r) begin
            i_nxt     = '0;
            state_nxt = ST_OUT;
          end else if (j_r >= cnt_r) begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + IW'(2);
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_ROWEND: begin
        cmd.op = OP_ROWEND;
        if (i_r + 1'b1 == cnt_r) begin
          phase_nxt = 1'b1;
          i_nxt     = '0;
          j_nxt     = IW'(1);
          state_nxt = ST_SEL;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_ROW;
        end
      end
      ST_RD: begin
        cmd.op    = OP_READ;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if ((phase_r && stat.ws_zero) || stat.early_zero) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_SEL;
        end else begin
          cmd.op    = OP_DIVK;
          state_nxt = ST_KW;
        end
      end
      ST_KW: begin
        if (stat.div_done) begin
          if (stat.k_big) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_SEL;
          end else begin
            cmd.op    = OP_SQRT;
            state_nxt = ST_SW;
          end
        end
      end
      ST_SW: begin
        if (stat.sqrt_done) begin
          cmd.op    = OP_DIVW;
          state_nxt = ST_WW;
        end
      end
      ST_WW: begin
        if (stat.div_done) begin
          if (!phase_r) begin
            cmd.op    = OP_ACC;
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_SEL;
          end else if (stat.w_zero) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_SEL;
          end else begin
            cmd.op    = OP_MULG;
            axis_nxt  = 1'b0;
            state_nxt = ST_MD;
          end
        end
      end
      ST_MD: begin
        cmd.op    = OP_MULD;
        state_nxt = ST_DI;
      end
      ST_DI: begin
        cmd.op    = OP_DIVI;
        state_nxt = ST_DIW;
      end
      ST_DIW: begin
        if (stat.div_done) begin
          cmd.op    = OP_LATI;
          state_nxt = ST_DJ;
        end
      end
      ST_DJ: begin
        cmd.op    = OP_DIVJ;
        state_nxt = ST_DJW;
      end
      ST_DJW: begin
        if (stat.div_done) begin
          cmd.op    = OP_LATJ;
          state_nxt = ST_WI;
        end
      end
      ST_WI: begin
        cmd.op    = OP_WRI;
        state_nxt = ST_WJ;
      end
      ST_WJ: begin
        cmd.op = OP_WRJ;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_MD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_SEL;
        end
      end
      ST_OUT: begin
        cmd.op    = OP_OUTRD;
        state_nxt = ST_OEMIT;
      end
      ST_OEMIT: begin
        out_valid = 1'b1;
        out_last  = (i_r + 1'b1 == cnt_r);
        if (out_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_OUT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/gaussian_particle_repulsion.sv =====
// Top level of the Gaussian pairwise repulsion block.
// Depends on gpr_pkg, gpr_ctrl, gpr_datapath and the assertion macro header.

// Loads 2-D particles (Q8.8) one beat per cycle while busy is low; a beat with
// last_particle set runs the whole set and then emits one Q16.16 force per
// particle, in load order, each on out_valid for a single cycle with no way to
// stall it. An unmarked beat leaves busy low. The marked beat holds busy high
// through a weight pass over all ordered pairs, a force pass over unordered
// pairs and the emission of the forces. Almost all of that time is the shared
// restoring divider (kernel index, weight, and four force quotients per pair)
// and the square-root unit, both driven by the controller one pair step at a
// time. A pair beyond the cutoff is skipped after the distance check, one beyond
// the table after the kernel-index quotient. Particles past MAX_PARTICLES are
// dropped.
// No clearing pass: sums and forces are rewritten row by row in the weight pass of each run.
// Config writes are always ready and must only land while busy is low.
`include "gaussian_particle_repulsion_defines.svh"

module gaussian_particle_repulsion
  import gpr_pkg::*;
#(
  parameter int MAX_PARTICLES   = MAX_PARTICLES_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  // result beats
  output logic              out_valid,
  output out_item_t         out_data,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_PARTICLES);

  dp_cmd_t                   cmd;
  dp_stat_t                  stat;
  logic [AW-1:0]             idx_i, idx_j;
  logic                      out_last;
  logic signed [FORCE_W-1:0] force_x, force_y;

  // register file never back-pressures
  assign cfg_ready = 1'b1;

  gpr_ctrl #(
    .MAX_P (MAX_PARTICLES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .last_particle (in_data.last_particle),
    .busy          (busy),
    .cmd           (cmd),
    .idx_i         (idx_i),
    .idx_j         (idx_j),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_last      (out_last)
  );

  gpr_datapath #(
    .MAX_P     (MAX_PARTICLES),
    .EXP_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .idx_i     (idx_i),
    .idx_j     (idx_j),
    .stat      (stat),
    .force_x   (force_x),
    .force_y   (force_y)
  );

  // force comes straight off the read registers of the force store
  assign out_data.force_x    = force_x;
  assign out_data.force_y    = force_y;
  assign out_data.last_force = out_last;

  // results only appear while a run is in progress
  `GPR_ASSERT_IMP(a_out_in_run, out_valid, busy, "result strobe while idle")
  // an unmarked particle is just stored
  `GPR_ASSERT_NXT(a_plain_load, start && !busy && !in_data.last_particle, !busy,
                  "unmarked particle started a run")
  // the final force ends the run
  `GPR_ASSERT_NXT(a_last_ends, out_valid && out_data.last_force, !busy,
                  "block still busy after final force")
  // each force takes a read beat before it is shown
  `GPR_ASSERT_NXT(a_gap, out_valid, !out_valid, "back-to-back result strobes")

endmodule

// ===== verif/gaussian_particle_repulsion_tb.sv =====
// Self-checking testbench for gaussian_particle_repulsion: random particle sets,
// register sweeps, and a force predictor checked against every result beat.
// Depends on gpr_pkg and the gaussian_particle_repulsion RTL.
module gaussian_particle_repulsion_tb;
  import gpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART = 64;
  localparam int TABN  = 256;
  localparam longint unsigned CYCLE_LIMIT = 40_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IW-1:0] cfg_index = REG_GAIN;
  logic [CFG_W-1:0]  cfg_data = '0;

  gaussian_particle_repulsion dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers, the loaded set and the
  // exp(-k/16) table built by the same Q0.32 recurrence.
  // ---------------------------------------------------------------------------
  logic [15:0]      gain_r = 16'd256, sigma_r = 16'd77, cutoff_r = 16'd128;
  longint           px [NPART];
  longint           py [NPART];
  longint unsigned  wsum [NPART];
  longint           fx [NPART];
  longint           fy [NPART];
  int               n_loaded = 0;
  longint unsigned  exp_lut [TABN];

  in_item_t  particle_q [$];   // beats waiting to be driven
  out_item_t force_q [$];      // forces still owed by the block
  int        errors = 0;
  int        beats_sent = 0, sets_run = 0, forces_seen = 0;
  bit        idling_on = 1'b1;
  int        idle_left = 0;
  longint unsigned cycles = 0;

  initial begin : build_lut
    longint unsigned e;
    e = 64'd1 << 32;
    for (int k = 0; k < TABN; k++) begin
      exp_lut[k] = (e + 64'h8000) >> 16;
      e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Q16.16 pair weight exp(-d^2/sigma^2)/d, zero beyond cutoff/table, at d=0 or at zero width
  function automatic longint unsigned pair_w(input int i, input int j);
    longint unsigned ax, ay, d2, c2, s2, k;
    ax = mag(px[i] - px[j]);
    ay = mag(py[i] - py[j]);
    d2 = ax * ax + ay * ay;
    c2 = longint'(cutoff_r) * longint'(cutoff_r);
    if (d2 == 0 || d2 >= c2 || sigma_r == 0) return 0;
    s2 = longint'(sigma_r) * longint'(sigma_r);
    k = (16 * d2 + s2 / 2) / s2;
    if (k >= TABN) return 0;
    return (exp_lut[k] * 256) / int_sqrt(d2);
  endfunction

  function automatic longint sat_acc(input longint acc, input longint t);
    longint s;
    s = acc + t;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  // signed term pair for one axis: +gain*w*diff/wsum_i on i, -gain*w*diff/wsum_j on j
  task automatic push_axis(input int i, input int j, input longint unsigned w,
                           input longint diff, ref longint f [NPART]);
    longint unsigned m;
    longint ti, tj;
    m  = longint'(gain_r) * w * mag(diff);
    ti = longint'(m / wsum[i]);
    tj = longint'(m / wsum[j]);
    if (diff < 0) begin
      ti = -ti;
      tj = -tj;
    end
    f[i] = sat_acc(f[i], ti);
    f[j] = sat_acc(f[j], -tj);
  endtask

  // one accepted beat: store it, and on the marker work out the whole set
  task automatic absorb_particle(input in_item_t it);
    longint unsigned s, w;
    out_item_t r;
    if (n_loaded < NPART) begin
      px[n_loaded] = longint'(it.pos_x);
      py[n_loaded] = longint'(it.pos_y);
      n_loaded++;
    end
    if (!it.last_particle) return;
    for (int i = 0; i < n_loaded; i++) begin
      s = 0;
      for (int j = 0; j < n_loaded; j++)
        if (j != i) s += pair_w(i, j);
      wsum[i] = (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
      fx[i] = 0;
      fy[i] = 0;
    end
    for (int i = 0; i < n_loaded; i++)
      for (int j = i + 1; j < n_loaded; j++) begin
        if (wsum[i] == 0 || wsum[j] == 0) continue;
        w = pair_w(i, j);
        if (w == 0) continue;
        push_axis(i, j, w, px[i] - px[j], fx);
        push_axis(i, j, w, py[i] - py[j], fy);
      end
    for (int i = 0; i < n_loaded; i++) begin
      r.force_x = 32'(fx[i]);
      r.force_y = 32'(fy[i]);
      r.last_force = (i == n_loaded - 1);
      force_q = {force_q, r};
    end
    n_loaded = 0;
    sets_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats on start, with random idle bursts.
  // start stays high across back-to-back beats (one NBA per edge).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_particle(in_data);
        void'(particle_q.pop_front());
        beats_sent++;
      end
      if (start && busy) begin
        // beat still waiting; hold it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (particle_q.size() > 0) begin
        start   <= 1'b1;
        in_data <= particle_q[0];
        if (idling_on && $urandom_range(0, 7) == 0)
          idle_left = $urandom_range(1, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: register writes update the predictor; each result beat is
  // checked field by field against the oldest owed force.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN:   gain_r   <= cfg_data;
        REG_WIDTH:  sigma_r  <= cfg_data;
        REG_CUTOFF: cutoff_r <= cfg_data;
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      out_item_t exp_f;
      forces_seen++;
      if (force_q.size() == 0) begin
        $error("unexpected force beat x=%0d y=%0d", out_data.force_x, out_data.force_y);
        errors++;
      end else begin
        exp_f = force_q.pop_front();
        if (out_data.force_x !== exp_f.force_x) begin
          $error("force_x expected %0d actual %0d", exp_f.force_x, out_data.force_x);
          errors++;
        end
        if (out_data.force_y !== exp_f.force_y) begin
          $error("force_y expected %0d actual %0d", exp_f.force_y, out_data.force_y);
          errors++;
        end
        if (out_data.last_force !== exp_f.last_force) begin
          $error("last_force expected %0b actual %0b", exp_f.last_force,
                 out_data.last_force);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL gaussian_particle_repulsion");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk(input int x, input int y, input bit last);
    in_item_t it;
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.last_particle = last;
    return it;
  endfunction

  // append one beat to the pending queue
  task automatic queue_particle(input in_item_t it);
    particle_q = {particle_q, it};
  endtask

  // wait for the block to drain: queue empty, no force owed, busy low
  task automatic drain();
    while (particle_q.size() > 0 || start || force_q.size() > 0 || busy)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int g, input int w, input int c);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_WIDTH, w);
    write_reg(REG_CUTOFF, c);
  endtask

  // a cluster of n particles around a random centre; a few are noise
  task automatic queue_cluster(input int n, input int spread);
    int cx, cy;
    cx = $urandom_range(0, 64000) - 32000;
    cy = $urandom_range(0, 64000) - 32000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_particle(mk($urandom(), $urandom(), i == n - 1));
      else
        queue_particle(mk(cx + $urandom_range(0, 2 * spread) - spread,
                          cy + $urandom_range(0, 2 * spread) - spread,
                          i == n - 1));
    end
  endtask

  initial begin
    int budget, n, spread;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset registers: lone particle, coincident pair, close pair,
    // out-of-cutoff pair, close triple
    queue_particle(mk(0, 0, 1'b1));
    queue_particle(mk(100, -100, 1'b0));
    queue_particle(mk(100, -100, 1'b1));
    queue_particle(mk(0, 0, 1'b0));
    queue_particle(mk(40, 30, 1'b1));
    queue_particle(mk(0, 0, 1'b0));
    queue_particle(mk(200, 0, 1'b1));
    queue_particle(mk(-32768, 32767, 1'b0));
    queue_particle(mk(-32700, 32740, 1'b0));
    queue_particle(mk(-32768, 32700, 1'b1));

    // position extremes at full width, cutoff and gain; the corner pairs still fall outside the cutoff
    set_regs(65535, 65535, 65535);
    queue_particle(mk(-32768, -32768, 1'b0));
    queue_particle(mk(32767, 32767, 1'b0));
    queue_particle(mk(32767, -32768, 1'b0));
    queue_particle(mk(1, -1, 1'b1));

    // narrow kernel: the far pairs fall off the end of the exp table, the unit-distance pair does not
    set_regs(256, 1, 65535);
    queue_particle(mk(0, 0, 1'b0));
    queue_particle(mk(60, 0, 1'b0));
    queue_particle(mk(0, 1, 1'b1));

    // zero kernel width
    set_regs(512, 0, 65535);
    queue_particle(mk(0, 0, 1'b0));
    queue_particle(mk(10, 20, 1'b1));

    // store full: cutoff zero keeps the 64-particle run cheap; two dropped
    set_regs(256, 77, 0);
    for (int i = 0; i < NPART + 2; i++)
      queue_particle(mk($urandom(), $urandom(), i == NPART + 1));

    // random sets under a sweep of register settings
    budget = 340;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(256, 77, 128);
        1: set_regs(0, 1, 1);
        2: set_regs(65535, 300, 400);
        3: set_regs($urandom_range(0, 65535), $urandom_range(20, 200),
                    $urandom_range(50, 600));
        default: set_regs(1024, 65535, 65535);
      endcase
      for (int got = 0; got < budget / 5; got += n) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        spread = (ph == 4) ? 60 : $urandom_range(20, 150);
        if (ph == 4) idling_on = 1'b0;  // closing stretch runs back to back
        queue_cluster(n, spread);
        while (particle_q.size() > 4) @(posedge clk);
      end
    end

    drain();
    $display("%0d particle beats, %0d sets, %0d forces checked; gain, width and",
             beats_sent, sets_run, forces_seen);
    $display("cutoff swept across their extremes, including a full store");
    if (errors == 0) begin
      $display("PASS gaussian_particle_repulsion");
    end else begin
      $display("FAIL gaussian_particle_repulsion");
    end
    $finish;
  end

endmodule
